FILE: src/ps2_mouse_cursor_tracker_defines.svh
// Assertion helpers for the cursor tracker.
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define PS2MCT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PS2MCT_CHECK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2MCT_CHECK(lbl, prop, msg)
`define PS2MCT_CHECK_NR(lbl, prop, msg)
`endif

`endif

FILE: src/ps2mct_pkg.sv
package ps2mct_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;

  localparam logic signed [CFG_W-1:0] X_LOW_RST  = -12'sd512;
  localparam logic signed [CFG_W-1:0] X_HIGH_RST = 12'sd482;
  localparam logic signed [CFG_W-1:0] Y_LOW_RST  = -12'sd384;
  localparam logic signed [CFG_W-1:0] Y_HIGH_RST = 12'sd356;

  // ops
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // packet phase
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // bits of packet byte 0
  localparam int LB_BIT   = 0;
  localparam int RB_BIT   = 1;
  localparam int MB_BIT   = 2;
  localparam int SYNC_BIT = 3;
  localparam int XS_BIT   = 4;
  localparam int YS_BIT   = 5;

  // button flag bits
  localparam int FL_LEFT  = 0;
  localparam int FL_MID   = 1;
  localparam int FL_RIGHT = 2;
  localparam int FL_REL   = 3;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [3:0] flags;
  } pkt_state_t;

endpackage

FILE: src/ps2mct_if.sv
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ps2mct_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  packet_done;
  logic                                  left_button;
  logic                                  middle_button;
  logic                                  right_button;
  logic                                  left_released;
  logic signed [ps2mct_pkg::OUT_W-1:0]   cursor_x;
  logic signed [ps2mct_pkg::OUT_W-1:0]   cursor_y;

  modport source (output valid, output packet_done, output left_button,
                  output middle_button, output right_button, output left_released,
                  output cursor_x, output cursor_y, input ready);
  modport sink   (input valid, input packet_done, input left_button,
                  input middle_button, input right_button, input left_released,
                  input cursor_x, input cursor_y, output ready);
endinterface

FILE: src/ps2mct_packet.sv
module ps2mct_packet #(
  parameter int SUM_WIDTH = 16
) (
  input  ps2mct_pkg::pkt_state_t        cur,
  input  logic [1:0]                    op,
  input  logic [7:0]                    data_byte,
  input  logic signed [SUM_WIDTH-1:0]   sum_x,
  input  logic signed [SUM_WIDTH-1:0]   sum_y,
  output ps2mct_pkg::pkt_state_t        nxt,
  output logic                          done,
  output logic signed [SUM_WIDTH-1:0]   sum_x_nxt,
  output logic signed [SUM_WIDTH-1:0]   sum_y_nxt
);

  logic [7:0]               b0;
  logic [3:0]               flags_pkt;
  logic signed [8:0]        dx;
  logic signed [8:0]        dy;
  logic [SUM_WIDTH:0]       wide_x;
  logic [SUM_WIDTH:0]       wide_y;
  logic [SUM_WIDTH-1:0]     sat_x;
  logic [SUM_WIDTH-1:0]     sat_y;

  assign b0 = cur.first_byte;
  assign dx = {b0[ps2mct_pkg::XS_BIT], cur.second_byte};
  assign dy = {b0[ps2mct_pkg::YS_BIT], data_byte};

  always_comb begin
    flags_pkt = cur.flags;
    flags_pkt[ps2mct_pkg::FL_LEFT]  = b0[ps2mct_pkg::LB_BIT];
    // release flag keeps its value while left is held
    if (!b0[ps2mct_pkg::LB_BIT]) begin
      flags_pkt[ps2mct_pkg::FL_REL] = cur.flags[ps2mct_pkg::FL_LEFT];
    end
    flags_pkt[ps2mct_pkg::FL_MID]   = b0[ps2mct_pkg::MB_BIT];
    flags_pkt[ps2mct_pkg::FL_RIGHT] = b0[ps2mct_pkg::RB_BIT];
  end

  assign wide_x = (SUM_WIDTH + 1)'(sum_x) + (SUM_WIDTH + 1)'(dx);
  assign wide_y = (SUM_WIDTH + 1)'(sum_y) + (SUM_WIDTH + 1)'(dy);

  // saturate on signed overflow of the accumulator
  assign sat_x = (wide_x[SUM_WIDTH] != wide_x[SUM_WIDTH-1]) ?
                 {wide_x[SUM_WIDTH], {(SUM_WIDTH-1){~wide_x[SUM_WIDTH]}}} :
                 wide_x[SUM_WIDTH-1:0];
  assign sat_y = (wide_y[SUM_WIDTH] != wide_y[SUM_WIDTH-1]) ?
                 {wide_y[SUM_WIDTH], {(SUM_WIDTH-1){~wide_y[SUM_WIDTH]}}} :
                 wide_y[SUM_WIDTH-1:0];

  always_comb begin
    nxt       = cur;
    done      = 1'b0;
    sum_x_nxt = sum_x;
    sum_y_nxt = sum_y;
    unique case (op)
      ps2mct_pkg::OP_BYTE: begin
        unique case (cur.phase)
          ps2mct_pkg::PH_SECOND: begin
            nxt.second_byte = data_byte;
            nxt.phase       = ps2mct_pkg::PH_THIRD;
          end
          ps2mct_pkg::PH_THIRD: begin
            nxt.flags = flags_pkt;
            nxt.phase = ps2mct_pkg::PH_FIRST;
            sum_x_nxt = $signed(sat_x);
            sum_y_nxt = $signed(sat_y);
            done      = 1'b1;
          end
          default: begin
            // unsynced first byte is dropped
            nxt.phase = ps2mct_pkg::PH_FIRST;
            if (data_byte[ps2mct_pkg::SYNC_BIT]) begin
              nxt.first_byte = data_byte;
              nxt.phase      = ps2mct_pkg::PH_SECOND;
            end
          end
        endcase
      end
      ps2mct_pkg::OP_FRAME: begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
      end
      ps2mct_pkg::OP_CLEAR: begin
        nxt.flags = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/ps2mct_cursor.sv
module ps2mct_cursor #(
  parameter int SUM_WIDTH = 16,
  parameter int POS_WIDTH = 12
) (
  input  logic signed [POS_WIDTH-1:0]          pos,
  input  logic signed [SUM_WIDTH-1:0]          delta,
  input  logic                                 invert,
  input  logic signed [ps2mct_pkg::CFG_W-1:0]  bound_lo,
  input  logic signed [ps2mct_pkg::CFG_W-1:0]  bound_hi,
  output logic signed [POS_WIDTH-1:0]          pos_nxt
);

  localparam int MAXW = (SUM_WIDTH > POS_WIDTH) ?
                        ((SUM_WIDTH > ps2mct_pkg::CFG_W) ? SUM_WIDTH : ps2mct_pkg::CFG_W) :
                        ((POS_WIDTH > ps2mct_pkg::CFG_W) ? POS_WIDTH : ps2mct_pkg::CFG_W);
  localparam int W = MAXW + 2;
  localparam logic signed [W-1:0] PMAX = W'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [W-1:0] PMIN = ~PMAX;

  logic signed [W-1:0] delta_e;
  logic signed [W-1:0] sum_v;
  logic signed [W-1:0] lo_e;
  logic signed [W-1:0] hi_e;
  logic signed [W-1:0] clamp_v;

  assign delta_e = invert ? -W'(delta) : W'(delta);
  assign sum_v   = W'(pos) + delta_e;
  assign lo_e    = W'(bound_lo);
  assign hi_e    = W'(bound_hi);

  always_comb begin
    clamp_v = sum_v;
    // upper bound first, so a crossed pair lands on the low bound
    if (clamp_v > hi_e) begin
      clamp_v = hi_e;
    end
    if (clamp_v < lo_e) begin
      clamp_v = lo_e;
    end
    if (clamp_v > PMAX) begin
      clamp_v = PMAX;
    end
    if (clamp_v < PMIN) begin
      clamp_v = PMIN;
    end
  end

  assign pos_nxt = clamp_v[POS_WIDTH-1:0];

endmodule

FILE: src/ps2_mouse_cursor_tracker.sv
// Path: an accepted input beat passes the input register, then the result
// register, before it leaves as a result beat.
// Throughput: one item per cycle while results are taken; the input register
// refills while a result waits, stalls only when both stages are full and the result is not taken.
// Reset: synchronous, active low; clears phase, flags, sums, cursor and
// loads the default bounds.
module ps2_mouse_cursor_tracker #(
  parameter int SUM_WIDTH = 16,
  parameter int POS_WIDTH = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  ps2mct_in_if.sink                              in_ch,
  ps2mct_out_if.source                           out_ch,
  input  logic                                   cfg_we,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ps2mct_pkg::CFG_W-1:0]           cfg_wdata
);

  `include "ps2_mouse_cursor_tracker_defines.svh"

  logic signed [ps2mct_pkg::CFG_W-1:0] x_low_r, x_high_r, y_low_r, y_high_r;

  logic                         s1_valid_r;
  logic [1:0]                   s1_op_r;
  logic [7:0]                   s1_byte_r;

  ps2mct_pkg::pkt_state_t       pkt_r, pkt_nxt;
  logic signed [SUM_WIDTH-1:0]  sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic signed [POS_WIDTH-1:0]  pos_x_r, pos_y_r, pos_x_frame, pos_y_frame;
  logic signed [POS_WIDTH-1:0]  pos_x_nxt, pos_y_nxt;
  logic                         done;

  logic                         out_valid_r;
  logic                         advance;
  logic                         commit;

  localparam int PEXT = (POS_WIDTH > ps2mct_pkg::OUT_W) ? POS_WIDTH : ps2mct_pkg::OUT_W;
  logic [PEXT-1:0]              px_ext, py_ext;

  assign advance      = !out_valid_r || out_ch.ready;
  assign commit       = advance && s1_valid_r;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= ps2mct_pkg::X_LOW_RST;
      x_high_r <= ps2mct_pkg::X_HIGH_RST;
      y_low_r  <= ps2mct_pkg::Y_LOW_RST;
      y_high_r <= ps2mct_pkg::Y_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2mct_pkg::CFG_X_LOW:  x_low_r  <= $signed(cfg_wdata);
        ps2mct_pkg::CFG_X_HIGH: x_high_r <= $signed(cfg_wdata);
        ps2mct_pkg::CFG_Y_LOW:  y_low_r  <= $signed(cfg_wdata);
        ps2mct_pkg::CFG_Y_HIGH: y_high_r <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  ps2mct_packet #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_packet (
    .cur       (pkt_r),
    .op        (s1_op_r),
    .data_byte (s1_byte_r),
    .sum_x     (sum_x_r),
    .sum_y     (sum_y_r),
    .nxt       (pkt_nxt),
    .done      (done),
    .sum_x_nxt (sum_x_nxt),
    .sum_y_nxt (sum_y_nxt)
  );

  ps2mct_cursor #(
    .SUM_WIDTH (SUM_WIDTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_cursor_x (
    .pos      (pos_x_r),
    .delta    (sum_x_r),
    .invert   (1'b0),
    .bound_lo (x_low_r),
    .bound_hi (x_high_r),
    .pos_nxt  (pos_x_frame)
  );

  // screen y grows downward, mouse y upward
  ps2mct_cursor #(
    .SUM_WIDTH (SUM_WIDTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_cursor_y (
    .pos      (pos_y_r),
    .delta    (sum_y_r),
    .invert   (1'b1),
    .bound_lo (y_low_r),
    .bound_hi (y_high_r),
    .pos_nxt  (pos_y_frame)
  );

  assign pos_x_nxt = (s1_op_r == ps2mct_pkg::OP_FRAME) ? pos_x_frame : pos_x_r;
  assign pos_y_nxt = (s1_op_r == ps2mct_pkg::OP_FRAME) ? pos_y_frame : pos_y_r;
  assign px_ext    = PEXT'(pos_x_nxt);
  assign py_ext    = PEXT'(pos_y_nxt);

  // state and result register both load when the item leaves stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (commit) begin
        pkt_r   <= pkt_nxt;
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.packet_done   <= done;
      out_ch.left_button   <= pkt_nxt.flags[ps2mct_pkg::FL_LEFT];
      out_ch.middle_button <= pkt_nxt.flags[ps2mct_pkg::FL_MID];
      out_ch.right_button  <= pkt_nxt.flags[ps2mct_pkg::FL_RIGHT];
      out_ch.left_released <= pkt_nxt.flags[ps2mct_pkg::FL_REL];
      out_ch.cursor_x      <= $signed(px_ext[ps2mct_pkg::OUT_W-1:0]);
      out_ch.cursor_y      <= $signed(py_ext[ps2mct_pkg::OUT_W-1:0]);
    end
  end

  `PS2MCT_CHECK(a_done_phase,
    out_valid_r && out_ch.packet_done |-> pkt_r.phase == ps2mct_pkg::PH_FIRST,
    "packet done but phase not back at first byte")
  `PS2MCT_CHECK_NR(a_ready_when_empty,
    !out_valid_r |-> in_ch.ready,
    "input stalled with empty result register")
  `PS2MCT_CHECK(a_hold_on_stall,
    out_valid_r && !out_ch.ready |=> $stable(pos_x_r) && $stable(pos_y_r) &&
      $stable(pkt_r),
    "tracker state moved while result stalled")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ps2mct_pkg::*;

  localparam int SUM_W = 16;
  localparam int POS_W = 12;
  localparam int SUM_MAX = (1 << (SUM_W - 1)) - 1;
  localparam int SUM_MIN = -SUM_MAX - 1;
  localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN = -POS_MAX - 1;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CFG_REG_COUNT = 4;
  localparam logic signed [CFG_W-1:0] BOUND_MIN = {1'b1, {(CFG_W-1){1'b0}}};
  localparam logic signed [CFG_W-1:0] BOUND_MAX = {1'b0, {(CFG_W-1){1'b1}}};

  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 196;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                    packet_done;
    logic                    left_button;
    logic                    middle_button;
    logic                    right_button;
    logic                    left_released;
    logic signed [OUT_W-1:0] cursor_x;
    logic signed [OUT_W-1:0] cursor_y;
  } cursor_report_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  ps2mct_in_if  in_ch ();
  ps2mct_out_if out_ch ();

  ps2_mouse_cursor_tracker #(
    .SUM_WIDTH(SUM_W),
    .POS_WIDTH(POS_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker state as the block should hold it
  logic [1:0]              pkt_phase;
  logic [7:0]              hdr_byte;
  logic [7:0]              x_byte;
  logic [3:0]              btn_flags;
  logic signed [SUM_W-1:0] acc_x;
  logic signed [SUM_W-1:0] acc_y;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic signed [CFG_W-1:0] lim_x_lo;
  logic signed [CFG_W-1:0] lim_x_hi;
  logic signed [CFG_W-1:0] lim_y_lo;
  logic signed [CFG_W-1:0] lim_y_hi;

  cursor_report_t pending_reports[$];
  int fail_count = 0;
  int report_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_trigger = 0;

  function automatic logic signed [SUM_W-1:0] sat_sum(input int v);
    if (v > SUM_MAX) v = SUM_MAX;
    if (v < SUM_MIN) v = SUM_MIN;
    return v[SUM_W-1:0];
  endfunction

  // upper bound first, so an inverted window lands on the lower bound
  function automatic logic signed [POS_W-1:0] frame_axis(input int pos, input int delta,
                                                         input int lo, input int hi);
    int v;
    v = pos + delta;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[POS_W-1:0];
  endfunction

  task automatic reset_tracker_model();
    pkt_phase = PH_FIRST;
    hdr_byte = '0;
    x_byte = '0;
    btn_flags = '0;
    acc_x = '0;
    acc_y = '0;
    cur_x = '0;
    cur_y = '0;
    lim_x_lo = X_LOW_RST;
    lim_x_hi = X_HIGH_RST;
    lim_y_lo = Y_LOW_RST;
    lim_y_hi = Y_HIGH_RST;
  endtask

  task automatic close_packet(input logic [7:0] y_byte);
    logic [3:0] f;
    int dx;
    int dy;
    f = btn_flags;
    dx = int'(x_byte) - (hdr_byte[XS_BIT] ? 256 : 0);
    dy = int'(y_byte) - (hdr_byte[YS_BIT] ? 256 : 0);
    if (hdr_byte[LB_BIT]) begin
      f[FL_LEFT] = 1'b1;
    end else begin
      f[FL_REL] = f[FL_LEFT];
      f[FL_LEFT] = 1'b0;
    end
    f[FL_MID] = hdr_byte[MB_BIT];
    f[FL_RIGHT] = hdr_byte[RB_BIT];
    btn_flags = f;
    acc_x = sat_sum(int'(acc_x) + dx);
    acc_y = sat_sum(int'(acc_y) + dy);
  endtask

  task automatic track_cursor(input logic [1:0] op, input logic [7:0] data);
    cursor_report_t r;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (pkt_phase == PH_SECOND) begin
          x_byte = data;
          pkt_phase = PH_THIRD;
        end else if (pkt_phase == PH_THIRD) begin
          close_packet(data);
          pkt_phase = PH_FIRST;
          r.packet_done = 1'b1;
        end else if (data[SYNC_BIT]) begin
          hdr_byte = data;
          pkt_phase = PH_SECOND;
        end else begin
          pkt_phase = PH_FIRST;
        end
      end
      OP_FRAME: begin
        cur_x = frame_axis(cur_x, int'(acc_x), lim_x_lo, lim_x_hi);
        cur_y = frame_axis(cur_y, -int'(acc_y), lim_y_lo, lim_y_hi);
        acc_x = '0;
        acc_y = '0;
      end
      OP_CLEAR: btn_flags = '0;
      default: ;
    endcase
    r.left_button = btn_flags[FL_LEFT];
    r.middle_button = btn_flags[FL_MID];
    r.right_button = btn_flags[FL_RIGHT];
    r.left_released = btn_flags[FL_REL];
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    pending_reports.push_back(r);
  endtask

  // sender: bursts of random length, random gaps between them unless no_gaps is set
  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!no_gaps) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    track_cursor(op, data);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    send_item(OP_BYTE, hdr);
    send_item(OP_BYTE, xb);
    send_item(OP_BYTE, yb);
  endtask

  function automatic logic [7:0] pkt_header(input bit left, input bit right,
                                            input bit middle, input bit xs, input bit ys);
    logic [7:0] h;
    h = '0;
    h[LB_BIT] = left;
    h[RB_BIT] = right;
    h[MB_BIT] = middle;
    h[XS_BIT] = xs;
    h[YS_BIT] = ys;
    h[SYNC_BIT] = 1'b1;
    return h;
  endfunction

  task automatic send_random_packet();
    logic [7:0] h;
    h = 8'($urandom);
    h[SYNC_BIT] = 1'b1;
    send_packet(h, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_X_LOW:  lim_x_lo = val;
      CFG_X_HIGH: lim_x_hi = val;
      CFG_Y_LOW:  lim_y_lo = val;
      CFG_Y_HIGH: lim_y_hi = val;
      default: ;
    endcase
  endtask

  task automatic load_bounds(input logic signed [CFG_W-1:0] xl, input logic signed [CFG_W-1:0] xh,
                             input logic signed [CFG_W-1:0] yl, input logic signed [CFG_W-1:0] yh);
    wait_idle();
    write_reg(CFG_X_LOW, xl);
    write_reg(CFG_X_HIGH, xh);
    write_reg(CFG_Y_LOW, yl);
    write_reg(CFG_Y_HIGH, yh);
    // index past the register file must not alias onto a bound
    write_reg(CFG_IDX_W'($urandom_range(CFG_REG_COUNT, (1 << CFG_IDX_W) - 1)),
              CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CFG_W-1:0] rand_bound();
    case ($urandom_range(0, 3))
      0: return BOUND_MIN;
      1: return BOUND_MAX;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic move_and_frame(input int n);
    repeat (n) send_random_packet();
    send_item(OP_FRAME, 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hF7);
    send_packet(8'hFF, 8'hFF, 8'hFF);
    send_packet(pkt_header(0, 0, 0, 0, 0), 8'h00, 8'h00);
    send_packet(pkt_header(1, 0, 0, 0, 1), 8'hFF, 8'h00);
    send_item(OP_FRAME, 8'h00);
    send_packet(pkt_header(0, 1, 1, 1, 0), 8'h00, 8'hFF);
    send_item(OP_CLEAR, 8'h5A);
    send_item(OP_UNUSED, 8'hA5);
    // ops in the middle of a packet leave its phase alone
    send_item(OP_BYTE, pkt_header(1, 0, 1, 0, 0));
    send_item(OP_FRAME, 8'hFF);
    send_item(OP_BYTE, 8'h08);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_FRAME, 8'hFF);
    send_packet(pkt_header(0, 0, 0, 1, 1), 8'h80, 8'h80);
  endtask

  task automatic test_bounds();
    load_bounds(BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX);
    move_and_frame(4);
    load_bounds(12'sd100, -12'sd100, BOUND_MAX, BOUND_MIN);
    move_and_frame(2);
    send_item(OP_FRAME, 8'h00);
    load_bounds('0, '0, '0, '0);
    move_and_frame(3);
    load_bounds(BOUND_MAX, BOUND_MAX, BOUND_MIN, BOUND_MIN);
    move_and_frame(3);
    repeat (3) begin
      load_bounds(rand_bound(), rand_bound(), rand_bound(), rand_bound());
      move_and_frame($urandom_range(1, 6));
    end
    load_bounds(X_LOW_RST, X_HIGH_RST, Y_LOW_RST, Y_HIGH_RST);
    move_and_frame(5);
  endtask

  // enough full-scale packets without a frame to pin both sums at their limits
  task automatic test_saturation();
    load_bounds(BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX);
    repeat (129) send_packet(pkt_header(1'($urandom), 1'($urandom), 1'($urandom), 0, 1),
                             8'hFF, 8'h00);
    send_item(OP_FRAME, 8'h00);
    send_item(OP_FRAME, 8'h00);
  endtask

  task automatic test_backpressure();
    wait_idle();
    no_gaps = 1'b1;
    hold_trigger <= hold_trigger + 1;
    repeat (16) send_random_packet();
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    int counted;
    int pick;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_random_packet();
        counted += 3;
      end else if (pick < 80) begin
        send_item(OP_FRAME, 8'($urandom));
        counted++;
      end else if (pick < 86) begin
        send_item(OP_CLEAR, 8'($urandom));
        counted++;
      end else if (pick < 89) begin
        send_item(OP_UNUSED, 8'($urandom));
        counted++;
      end else if (pick < 95) begin
        // noise without sync; dropped unless a packet is open
        send_item(OP_BYTE, 8'($urandom) & ~(8'h01 << SYNC_BIT));
        counted++;
      end else if (pick < 99) begin
        send_item(OP_BYTE, 8'($urandom) | (8'h01 << SYNC_BIT));
        send_item($urandom_range(0, 1) ? OP_FRAME : OP_CLEAR, 8'($urandom));
        send_item(OP_BYTE, 8'($urandom));
        send_item(OP_BYTE, 8'($urandom));
        counted += 4;
      end else begin
        load_bounds(rand_bound(), rand_bound(), rand_bound(), rand_bound());
      end
    end
  endtask

  // receiver: stall pattern of its own, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int span;
    int hold_left;
    int hold_seen;
    mode = RX_OPEN;
    span = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(5, 60);
        end
        span--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= span[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_reports
    cursor_report_t seen;
    cursor_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.packet_done = out_ch.packet_done;
      seen.left_button = out_ch.left_button;
      seen.middle_button = out_ch.middle_button;
      seen.right_button = out_ch.right_button;
      seen.left_released = out_ch.left_released;
      seen.cursor_x = out_ch.cursor_x;
      seen.cursor_y = out_ch.cursor_y;
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: result beat with nothing expected: %p", $time, seen);
        end
      end else begin
        want = pending_reports.pop_front();
        if (seen.packet_done !== want.packet_done ||
            seen.left_button !== want.left_button ||
            seen.middle_button !== want.middle_button ||
            seen.right_button !== want.right_button ||
            seen.left_released !== want.left_released ||
            seen.cursor_x !== want.cursor_x ||
            seen.cursor_y !== want.cursor_y) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: mismatch expected %p", $time, want);
            $display("%0t:          actual   %p", $time, seen);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_BYTE;
    in_ch.data_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_X_LOW;
    cfg_wdata <= '0;
    reset_tracker_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_bounds();
    test_saturation();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: ps2_mouse_cursor_tracker.f
+incdir+src
src/ps2mct_pkg.sv
src/ps2mct_if.sv
src/ps2mct_packet.sv
src/ps2mct_cursor.sv
src/ps2_mouse_cursor_tracker.sv
bench/tb_top.sv
